### hw/rtl/vash_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vash_pkg
// shared types and constants of the vital alarm sustain and holdoff block
// ----------------------------------------------------------------------------
package vash_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_COND   = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SIGNAL_QUALITY = 3'd0,
    CFG_WARMUP_BEATS       = 3'd1,
    CFG_HR_HIGH_LIMIT      = 3'd2,
    CFG_HR_LOW_LIMIT       = 3'd3,
    CFG_SPO2_LOW_LIMIT     = 3'd4,
    CFG_SUSTAIN_MS         = 3'd5,
    CFG_REPEAT_MS          = 3'd6
  } cfg_idx_t;

  // condition slots
  typedef enum logic [1:0] {
    COND_HR_HIGH  = 2'd0,
    COND_HR_LOW   = 2'd1,
    COND_SPO2_LOW = 2'd2
  } cond_t;

  typedef struct packed {
    logic [6:0]  min_signal_quality;
    logic [7:0]  warmup_beats;
    logic [7:0]  hr_high_limit;
    logic [7:0]  hr_low_limit;
    logic [6:0]  spo2_low_limit;
    logic [31:0] sustain_ms;
    logic [31:0] repeat_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_signal_quality: 7'd60,
    warmup_beats:       8'd8,
    hr_high_limit:      8'd120,
    hr_low_limit:       8'd40,
    spo2_low_limit:     7'd90,
    sustain_ms:         32'd10000,
    repeat_ms:          32'd60000
  };

  typedef struct packed {
    logic [31:0] time_ms;
    logic        hr_valid;
    logic        spo2_valid;
    logic [6:0]  signal_quality;
    logic        skin_contact;
    logic [7:0]  beats_since_contact;
    logic        motion_artifact;
    logic [7:0]  heart_rate;
    logic [6:0]  spo2_percent;
  } in_item_t;

  typedef struct packed {
    logic        alert_hr_high;
    logic        alert_hr_low;
    logic        alert_spo2_low;
    logic [7:0]  reported_heart_rate;
    logic [6:0]  reported_spo2;
  } out_item_t;

  // timing limits handed to each condition tracker
  typedef struct packed {
    logic [31:0] sustain_ms;
    logic [31:0] repeat_ms;
  } timing_t;

endpackage
`default_nettype wire

### hw/rtl/vash_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vash_in_if
// sample request channel, valid and ready handshake
// ----------------------------------------------------------------------------
interface vash_in_if;
  logic               valid;
  logic               ready;
  vash_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/vash_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vash_out_if
// result request channel, valid and ready handshake
// ----------------------------------------------------------------------------
interface vash_out_if;
  logic                valid;
  logic                ready;
  vash_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/vash_cond.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vash_cond
// sustain timer and repeat holdoff of one alarm condition
// ----------------------------------------------------------------------------
module vash_cond (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              trusted,
  input  wire logic              breach,
  input  wire logic [31:0]       now,
  input  wire vash_pkg::timing_t timing,
  output logic                   alert
);

  logic        active_r, active_nxt;
  logic        sent_r, sent_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] last_r, last_nxt;
  logic        armed;
  logic [31:0] since_start;
  logic [31:0] since_last;

  always_comb begin
    armed       = trusted && breach;
    // wrapping elapsed times
    since_start = now - start_r;
    since_last  = now - last_r;
    alert       = armed && active_r && (since_start >= timing.sustain_ms)
                  && (!sent_r || (since_last >= timing.repeat_ms));

    active_nxt = active_r;
    start_nxt  = start_r;
    sent_nxt   = sent_r;
    last_nxt   = last_r;
    if (en) begin
      active_nxt = armed;
      if (armed && !active_r) begin
        start_nxt = now;
      end
      if (alert) begin
        sent_nxt = 1'b1;
        last_nxt = now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sent_r   <= 1'b0;
      start_r  <= '0;
      last_r   <= '0;
    end else begin
      active_r <= active_nxt;
      sent_r   <= sent_nxt;
      start_r  <= start_nxt;
      last_r   <= last_nxt;
    end
  end

`ifndef SYNTHESIS
  // an alert needs an already armed timer
  a_alert_armed: assert property (@(posedge clk) disable iff (!rst_n)
    en && alert |-> active_r)
    else $error("alert without armed sustain timer");

  // a lost breach or lost trust disarms the timer
  a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    en && !(trusted && breach) |=> !active_r)
    else $error("sustain timer still armed after breach ended");

  // the sent flag only clears on reset
  a_sent_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r |=> sent_r)
    else $error("sent flag cleared outside reset");

  // an alert stamps its own time
  a_last_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    en && alert |=> sent_r && (last_r == $past(now)))
    else $error("last alert time not recorded");
`endif

endmodule
`default_nettype wire

### hw/rtl/vital_alarm_sustain_holdoff.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vital_alarm_sustain_holdoff
// three vital sign alarms with sustain time and repeat holdoff
// ----------------------------------------------------------------------------
// Takes one sample request per cycle while no result stalls and returns one
// result request per sample, in order. A sample waits in the input register,
// where the trust gates, the three limit compares and the three wrapping
// elapsed-time compares are evaluated; the alarm state is updated as the
// sample moves into the output register, so a sample passes the input and
// then the output register, and the sustained rate is one sample per clock
// while no result stalls. The rate is set by the registered update of the
// per-condition state (armed flag, breach start time, sent flag, last alert
// time), which the next sample reads straight away. A stalled result holds
// the output register; the input register can still take a new sample when
// the result leaves in the same cycle. The configuration port writes one
// register per cycle by index; indexes beyond the register list are ignored.
// Write configuration only while no sample is in flight.
// ----------------------------------------------------------------------------
module vital_alarm_sustain_holdoff (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  vash_in_if.sink                               in_ch,
  vash_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [vash_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vash_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  vash_pkg::cfg_t      cfg_r, cfg_nxt;

  // input register
  logic                s1_valid_r, s1_valid_nxt;
  vash_pkg::in_item_t  s1_data_r, s1_data_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  vash_pkg::out_item_t out_data_r, out_data_nxt;

  logic                out_free;
  logic                advance;
  logic                in_take;

  // trust and breach terms of the sample in the input register
  logic                base_ok;
  logic                hr_ok;
  logic                spo2_ok;
  logic [vash_pkg::NUM_COND-1:0] trusted;
  logic [vash_pkg::NUM_COND-1:0] breach;
  logic [vash_pkg::NUM_COND-1:0] alert;
  vash_pkg::timing_t   timing;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (vash_pkg::cfg_idx_t'(cfg_index))
        vash_pkg::CFG_MIN_SIGNAL_QUALITY: cfg_nxt.min_signal_quality = cfg_wdata[6:0];
        vash_pkg::CFG_WARMUP_BEATS:       cfg_nxt.warmup_beats       = cfg_wdata[7:0];
        vash_pkg::CFG_HR_HIGH_LIMIT:      cfg_nxt.hr_high_limit      = cfg_wdata[7:0];
        vash_pkg::CFG_HR_LOW_LIMIT:       cfg_nxt.hr_low_limit       = cfg_wdata[7:0];
        vash_pkg::CFG_SPO2_LOW_LIMIT:     cfg_nxt.spo2_low_limit     = cfg_wdata[6:0];
        vash_pkg::CFG_SUSTAIN_MS:         cfg_nxt.sustain_ms         = cfg_wdata[31:0];
        vash_pkg::CFG_REPEAT_MS:          cfg_nxt.repeat_ms          = cfg_wdata[31:0];
        // unused index, write dropped
        default:                          cfg_nxt = cfg_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the output register frees when empty or being drained, the
  // input register moves on when the output register is free
  // ---------------------------------------------------------------------------
  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    advance     = s1_valid_r && out_free;
    in_ch.ready = !s1_valid_r || advance;
    in_take     = in_ch.valid && in_ch.ready;
  end

  // ---------------------------------------------------------------------------
  // trust gates and limit compares, raw field values, no clamping
  // ---------------------------------------------------------------------------
  always_comb begin
    base_ok = (s1_data_r.signal_quality >= cfg_r.min_signal_quality)
              && s1_data_r.skin_contact;
    hr_ok   = s1_data_r.hr_valid && base_ok
              && (s1_data_r.beats_since_contact >= cfg_r.warmup_beats);
    spo2_ok = s1_data_r.spo2_valid && base_ok && !s1_data_r.motion_artifact;

    trusted[vash_pkg::COND_HR_HIGH]  = hr_ok;
    trusted[vash_pkg::COND_HR_LOW]   = hr_ok;
    trusted[vash_pkg::COND_SPO2_LOW] = spo2_ok;

    breach[vash_pkg::COND_HR_HIGH]   = s1_data_r.heart_rate > cfg_r.hr_high_limit;
    breach[vash_pkg::COND_HR_LOW]    = s1_data_r.heart_rate < cfg_r.hr_low_limit;
    breach[vash_pkg::COND_SPO2_LOW]  = s1_data_r.spo2_percent < cfg_r.spo2_low_limit;

    timing.sustain_ms = cfg_r.sustain_ms;
    timing.repeat_ms  = cfg_r.repeat_ms;
  end

  // one tracker per condition, state moves only when a sample advances
  for (genvar k = 0; k < vash_pkg::NUM_COND; k++) begin : g_cond
    vash_cond u_cond (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .trusted (trusted[k]),
      .breach  (breach[k]),
      .now     (s1_data_r.time_ms),
      .timing  (timing),
      .alert   (alert[k])
    );
  end

  // ---------------------------------------------------------------------------
  // pipeline register next values
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_ch.data;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt                    = 1'b1;
      out_data_nxt.alert_hr_high       = alert[vash_pkg::COND_HR_HIGH];
      out_data_nxt.alert_hr_low        = alert[vash_pkg::COND_HR_LOW];
      out_data_nxt.alert_spo2_low      = alert[vash_pkg::COND_SPO2_LOW];
      out_data_nxt.reported_heart_rate = s1_data_r.heart_rate;
      out_data_nxt.reported_spo2       = s1_data_r.spo2_percent;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= vash_pkg::CFG_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    s1_data_r  <= s1_data_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    out_ch.valid = out_valid_r;
    out_ch.data  = out_data_r;
  end

`ifndef SYNTHESIS
  // a sample held behind a stalled result stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register lost a sample under stall");

  // every advanced sample shows up as a result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced sample produced no result");

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_data_r))
    else $error("result changed under stall");
`endif

endmodule
`default_nettype wire
